FILE: rtl/label_blob_stats_accumulator_assert.svh
// Assertion macros of the blob statistics accumulator.
`ifndef LABEL_BLOB_STATS_ACCUMULATOR_ASSERT_SVH
`define LABEL_BLOB_STATS_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LBSA_ASSERT_NOW(name, clk, rst, cond, conseq, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define LBSA_ASSERT_NEXT(name, clk, rst, cond, conseq, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

FILE: rtl/lbsa_pkg.sv
// Types, constants and helper functions of the blob statistics accumulator.
package lbsa_pkg;

   localparam int LABELS     = 256;
   localparam int LABEL_BITS = (LABELS > 1) ? $clog2(LABELS) : 1;
   localparam int COORD_W    = 12;
   localparam int BOX_W      = COORD_W + 1;
   localparam int COUNT_W    = 24;
   localparam int SUM_W      = 32;
   localparam int VALUE_W    = 8;
   localparam int CSR_IDX_W  = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
   localparam logic [COORD_W-1:0] RESET_WIDTH  = COORD_W'(640);
   localparam logic [COORD_W-1:0] RESET_HEIGHT = COORD_W'(480);

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_ROI_TOP      = 3'd2,
      CSR_ROI_LEFT     = 3'd3,
      CSR_ROI_BOTTOM   = 3'd4,
      CSR_ROI_RIGHT    = 3'd5
   } csr_idx_type;

   // Actions carried by an input transaction.
   typedef enum logic {
      ACT_ACCUMULATE = 1'b0,
      ACT_READ       = 1'b1
   } action_type;

   typedef struct packed {
      logic [COORD_W-1:0] image_width;
      logic [COORD_W-1:0] image_height;
      logic [COORD_W-1:0] roi_top;
      logic [COORD_W-1:0] roi_left;
      logic [COORD_W-1:0] roi_bottom;
      logic [COORD_W-1:0] roi_right;
   } cfg_type;

   typedef struct packed {
      action_type         action;
      logic [7:0]         label;
      logic [VALUE_W-1:0] brightness;
      logic [VALUE_W-1:0] red;
      logic [VALUE_W-1:0] green;
      logic [VALUE_W-1:0] blue;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } item_type;

   // One label's record as it lives in the memory.
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [SUM_W-1:0]   bright_sum;
      logic [SUM_W-1:0]   red_sum;
      logic [SUM_W-1:0]   green_sum;
      logic [SUM_W-1:0]   blue_sum;
      logic [BOX_W-1:0]   left;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] right;
      logic [BOX_W-1:0]   bottom;
   } rec_type;

   // Write request to the record memory.
   typedef struct packed {
      logic                  en;
      logic [LABEL_BITS-1:0] addr;
      rec_type               rec;
   } wr_type;

   // Empty record for the given frame size.
   function automatic rec_type empty_rec(input logic [COORD_W-1:0] width,
                                         input logic [COORD_W-1:0] height);
      rec_type r;
      r            = '0;
      r.left       = {1'b0, width};
      r.top        = height;
      return r;
   endfunction

   // Saturating add of a pixel value to a running sum.
   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0]   acc,
                                                input logic [VALUE_W-1:0] v);
      logic [SUM_W:0] s;
      s = {1'b0, acc} + {{(SUM_W + 1 - VALUE_W){1'b0}}, v};
      return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
   endfunction

endpackage

FILE: rtl/lbsa_req_if.sv
// Input channel: labelled pixels and read requests.
interface lbsa_req_if;
   logic                           valid;
   logic                           ready;
   lbsa_pkg::action_type           action;
   logic [7:0]                     label;
   logic [lbsa_pkg::VALUE_W-1:0]   brightness;
   logic [lbsa_pkg::VALUE_W-1:0]   red;
   logic [lbsa_pkg::VALUE_W-1:0]   green;
   logic [lbsa_pkg::VALUE_W-1:0]   blue;
   logic [lbsa_pkg::COORD_W-1:0]   row;
   logic [lbsa_pkg::COORD_W-1:0]   col;

   modport source (output valid, action, label, brightness, red, green, blue, row, col,
                   input ready);
   modport sink   (input valid, action, label, brightness, red, green, blue, row, col,
                   output ready);
endinterface

FILE: rtl/lbsa_rsp_if.sv
// Result channel: one label record per read request.
interface lbsa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [7:0]                     label_out;
   logic [lbsa_pkg::COUNT_W-1:0]   pixel_count;
   logic [lbsa_pkg::SUM_W-1:0]     brightness_sum;
   logic [lbsa_pkg::SUM_W-1:0]     red_sum;
   logic [lbsa_pkg::SUM_W-1:0]     green_sum;
   logic [lbsa_pkg::SUM_W-1:0]     blue_sum;
   logic [lbsa_pkg::BOX_W-1:0]     box_left;
   logic [lbsa_pkg::COORD_W-1:0]   box_top;
   logic [lbsa_pkg::COORD_W-1:0]   box_right;
   logic [lbsa_pkg::BOX_W-1:0]     box_bottom;

   modport source (output valid, label_out, pixel_count, brightness_sum, red_sum,
                          green_sum, blue_sum, box_left, box_top, box_right, box_bottom,
                   input ready);
   modport sink   (input valid, label_out, pixel_count, brightness_sum, red_sum,
                         green_sum, blue_sum, box_left, box_top, box_right, box_bottom,
                   output ready);
endinterface

FILE: rtl/lbsa_csr_if.sv
// Configuration write channel.
interface lbsa_csr_if;
   logic                             valid;
   logic                             ready;
   logic [lbsa_pkg::CSR_IDX_W-1:0]   index;
   logic [lbsa_pkg::COORD_W-1:0]     wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

FILE: rtl/lbsa_record_store.sv
// Label record memory with registered read and per-entry valid bits.
module lbsa_record_store (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rd_en,
   input  logic [lbsa_pkg::LABEL_BITS-1:0] rd_addr,
   input  lbsa_pkg::wr_type                wr,
   output lbsa_pkg::rec_type               rd_rec
);

   lbsa_pkg::rec_type                mem [lbsa_pkg::LABELS];
   logic [lbsa_pkg::LABELS-1:0]      valid_ff;
   lbsa_pkg::rec_type                rd_rec_ff;
   logic                             rd_valid_ff;

   // Memory array: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.rec;
      end
      if (rd_en) begin
         rd_rec_ff <= mem[rd_addr];
      end
   end

   // Valid bits: an entry never written since reset holds the reset record.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_rec = rd_valid_ff ? rd_rec_ff
                               : lbsa_pkg::empty_rec(lbsa_pkg::RESET_WIDTH,
                                                     lbsa_pkg::RESET_HEIGHT);

endmodule

FILE: rtl/lbsa_update.sv
// Modify step: merges one pixel into its record or clears a record on read.
module lbsa_update (
   input  lbsa_pkg::item_type  item,
   input  lbsa_pkg::cfg_type   cfg,
   input  lbsa_pkg::rec_type   mem_rec,
   input  lbsa_pkg::wr_type    fwd,
   output lbsa_pkg::wr_type    wr,
   output lbsa_pkg::rec_type   rsp_rec
);

   logic [lbsa_pkg::LABEL_BITS-1:0] idx;
   logic                            in_range;
   logic                            in_roi;
   logic [lbsa_pkg::BOX_W-1:0]      col1;
   logic [lbsa_pkg::BOX_W-1:0]      row1;
   lbsa_pkg::rec_type               cur;
   lbsa_pkg::rec_type               acc;
   lbsa_pkg::rec_type               empty;

   assign idx      = item.label[lbsa_pkg::LABEL_BITS-1:0];
   assign in_range = {1'b0, item.label} < 9'(lbsa_pkg::LABELS);
   assign in_roi   = (item.row >= cfg.roi_top) && (item.row < cfg.roi_bottom) &&
                     (item.col >= cfg.roi_left) && (item.col < cfg.roi_right);
   assign col1     = {1'b0, item.col} + 13'd1;
   assign row1     = {1'b0, item.row} + 13'd1;
   assign empty    = lbsa_pkg::empty_rec(cfg.image_width, cfg.image_height);

   // The write of the previous transaction is not yet visible in the read data.
   assign cur = (fwd.en && (fwd.addr == idx)) ? fwd.rec : mem_rec;

   // Accumulated record.
   always_comb begin
      acc            = cur;
      acc.count      = (cur.count != lbsa_pkg::COUNT_MAX) ? cur.count + 24'd1 : cur.count;
      acc.bright_sum = lbsa_pkg::sat_add(cur.bright_sum, item.brightness);
      acc.red_sum    = lbsa_pkg::sat_add(cur.red_sum, item.red);
      acc.green_sum  = lbsa_pkg::sat_add(cur.green_sum, item.green);
      acc.blue_sum   = lbsa_pkg::sat_add(cur.blue_sum, item.blue);
      acc.left       = (cur.left > col1) ? col1 : cur.left;
      acc.top        = (cur.top > item.row) ? item.row : cur.top;
      acc.right      = (cur.right < item.col) ? item.col : cur.right;
      acc.bottom     = (cur.bottom < row1) ? row1 : cur.bottom;
   end

   // Write back: a read clears the record, a pixel with a nonzero label inside the ROI merges into it.
   always_comb begin
      wr.addr = idx;
      unique case (item.action)
         lbsa_pkg::ACT_READ: begin
            wr.en  = in_range;
            wr.rec = empty;
         end
         lbsa_pkg::ACT_ACCUMULATE: begin
            wr.en  = in_range && (item.label != 8'd0) && in_roi;
            wr.rec = acc;
         end
         default: begin
            wr.en  = 1'b0;
            wr.rec = acc;
         end
      endcase
   end

   // A label beyond the store reads as an empty record of the current frame size.
   assign rsp_rec = in_range ? cur : empty;

endmodule

FILE: rtl/label_blob_stats_accumulator.sv
// Top level of the labelled-pixel blob statistics accumulator.
// The block takes one transaction per clock: a labelled pixel, merged into that label's
// record (count, brightness and color sums, bounding box), or a read that returns one
// record and clears it. The record memory is read at the edge that accepts a transaction,
// and the record is modified and written back as it leaves the modify stage, while a read's
// result passes on through the output register; back-to-back transactions to the same label
// are served by forwarding from the write port. The rate is set by the single read and
// write port of the record memory: one transaction per cycle, with a read held back only
// while the previous result is still waiting on the result channel. There is no clearing
// pass after reset: per-label valid bits make every record read as empty until it is
// first written.
`include "label_blob_stats_accumulator_assert.svh"

module label_blob_stats_accumulator (
   input  logic        clock,
   input  logic        reset,
   lbsa_req_if.sink    req_chan,
   lbsa_rsp_if.source  rsp_chan,
   lbsa_csr_if.sink    csr_chan
);

   lbsa_pkg::cfg_type   cfg_ff;
   lbsa_pkg::item_type  req_item;
   lbsa_pkg::item_type  s1_item_ff;
   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic                s1_is_read;
   logic                s1_go;
   logic                out_free;
   logic                req_take;
   lbsa_pkg::rec_type   mem_rec;
   lbsa_pkg::rec_type   rsp_rec;
   lbsa_pkg::wr_type    upd_wr;
   lbsa_pkg::wr_type    mem_wr;
   lbsa_pkg::wr_type    fwd_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [7:0]          rsp_label_ff;
   lbsa_pkg::rec_type   rsp_rec_ff;

   // Configuration registers; the port never stalls.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= lbsa_pkg::RESET_WIDTH;
         cfg_ff.image_height <= lbsa_pkg::RESET_HEIGHT;
         cfg_ff.roi_top      <= '0;
         cfg_ff.roi_left     <= '0;
         cfg_ff.roi_bottom   <= lbsa_pkg::RESET_HEIGHT;
         cfg_ff.roi_right    <= lbsa_pkg::RESET_WIDTH;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            lbsa_pkg::CSR_IMAGE_WIDTH:  cfg_ff.image_width  <= csr_chan.wdata;
            lbsa_pkg::CSR_IMAGE_HEIGHT: cfg_ff.image_height <= csr_chan.wdata;
            lbsa_pkg::CSR_ROI_TOP:      cfg_ff.roi_top      <= csr_chan.wdata;
            lbsa_pkg::CSR_ROI_LEFT:     cfg_ff.roi_left     <= csr_chan.wdata;
            lbsa_pkg::CSR_ROI_BOTTOM:   cfg_ff.roi_bottom   <= csr_chan.wdata;
            lbsa_pkg::CSR_ROI_RIGHT:    cfg_ff.roi_right    <= csr_chan.wdata;
            default: begin
            end
         endcase
      end
   end

   // Gather the input transaction.
   assign req_item.action     = req_chan.action;
   assign req_item.label      = req_chan.label;
   assign req_item.brightness = req_chan.brightness;
   assign req_item.red        = req_chan.red;
   assign req_item.green      = req_chan.green;
   assign req_item.blue       = req_chan.blue;
   assign req_item.row        = req_chan.row;
   assign req_item.col        = req_chan.col;

   // Pipeline control: a read leaves the modify stage only when the output register frees.
   assign s1_is_read     = (s1_item_ff.action == lbsa_pkg::ACT_READ);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_go          = s1_valid_ff && (!s1_is_read || out_free);
   assign req_chan.ready = !s1_valid_ff || s1_go;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign s1_valid_in    = req_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_item;
      end
   end

   // Record memory, read at acceptance and written from the modify stage.
   lbsa_record_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_take),
      .rd_addr (req_chan.label[lbsa_pkg::LABEL_BITS-1:0]),
      .wr      (mem_wr),
      .rd_rec  (mem_rec)
   );

   lbsa_update u_update (
      .item    (s1_item_ff),
      .cfg     (cfg_ff),
      .mem_rec (mem_rec),
      .fwd     (fwd_ff),
      .wr      (upd_wr),
      .rsp_rec (rsp_rec)
   );

   always_comb begin
      mem_wr    = upd_wr;
      mem_wr.en = upd_wr.en && s1_go;
   end

   // Last write, forwarded to the transaction that read the memory in the same cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff.en <= 1'b0;
      end else if (mem_wr.en) begin
         fwd_ff.en   <= 1'b1;
         fwd_ff.addr <= mem_wr.addr;
         fwd_ff.rec  <= mem_wr.rec;
      end
   end

   // Output register.
   assign rsp_valid_in = (s1_go && s1_is_read) ? 1'b1
                                               : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_is_read) begin
         rsp_label_ff <= s1_item_ff.label;
         rsp_rec_ff   <= rsp_rec;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.label_out      = rsp_label_ff;
   assign rsp_chan.pixel_count    = rsp_rec_ff.count;
   assign rsp_chan.brightness_sum = rsp_rec_ff.bright_sum;
   assign rsp_chan.red_sum        = rsp_rec_ff.red_sum;
   assign rsp_chan.green_sum      = rsp_rec_ff.green_sum;
   assign rsp_chan.blue_sum       = rsp_rec_ff.blue_sum;
   assign rsp_chan.box_left       = rsp_rec_ff.left;
   assign rsp_chan.box_top        = rsp_rec_ff.top;
   assign rsp_chan.box_right      = rsp_rec_ff.right;
   assign rsp_chan.box_bottom     = rsp_rec_ff.bottom;

   // A stalled read keeps its place in the modify stage.
   `LBSA_ASSERT_NEXT(a_read_stall_holds, clock, reset,
      s1_valid_ff && s1_is_read && !out_free,
      s1_valid_ff && $stable(s1_item_ff.label), "stalled read lost its stage")

   // A read that leaves the modify stage shows up as the next result.
   `LBSA_ASSERT_NEXT(a_read_gives_result, clock, reset,
      s1_go && s1_is_read,
      rsp_valid_ff && (rsp_label_ff == $past(s1_item_ff.label)), "read gave no result")

   // A read of a stored label always clears the record.
   `LBSA_ASSERT_NOW(a_read_clears, clock, reset,
      s1_go && s1_is_read && ({1'b0, s1_item_ff.label} < 9'(lbsa_pkg::LABELS)),
      mem_wr.en, "read did not clear its record")

endmodule
